// ===== rtl/core/uaf_pkg.sv =====
`timescale 1ns / 1ps
package uaf_pkg;

	// divider geometry: quotient bits retired per stage and number of stages
	localparam int DIV_QBITS = 32;
	localparam int DIV_STEPS = 2;
	localparam int DIV_STAGES = DIV_QBITS / DIV_STEPS;
	// prep register + iteration stages + sign/saturate register
	localparam int DIV_LAT = DIV_STAGES + 2;
	// stages after the divider output up to the output register
	localparam int POST_LAT = 14;
	localparam int PIPE_DEPTH = DIV_LAT + POST_LAT;
	// side line tap that lines up with the divider output register
	localparam int TAP0 = DIV_LAT - 1;

	localparam logic signed [31:0] Q30_MAX = 32'sh7fff_ffff;
	localparam logic signed [31:0] Q30_MIN = -32'sh7fff_ffff - 32'sd1;
	localparam logic signed [47:0] F48_MAX = 48'sh7fff_ffff_ffff;
	localparam logic signed [47:0] F48_MIN = -48'sh7fff_ffff_ffff - 48'sd1;
	localparam logic signed [31:0] SCALE_RESET = 32'sd65536;

	// per-word data that rides alongside the arithmetic
	typedef struct packed {
		logic [19:0]        site;
		logic               last;
		logic               pos;
		logic signed [31:0] axis_x;
		logic signed [31:0] axis_y;
		logic signed [31:0] axis_z;
		logic signed [31:0] k1;
		logic signed [31:0] k2;
	} side_t;

	// clamp a 36 bit signed value to signed 32 bit
	function automatic logic signed [31:0] sat_q30(input logic signed [35:0] v);
		logic signed [31:0] r;
		if (v > 36'(Q30_MAX))
			r = Q30_MAX;
		else if (v < 36'(Q30_MIN))
			r = Q30_MIN;
		else
			r = v[31:0];
		return r;
	endfunction

	// clamp a 56 bit signed value to signed 48 bit
	function automatic logic signed [47:0] sat_f48(input logic signed [55:0] v);
		logic signed [47:0] r;
		if (v > 56'(F48_MAX))
			r = F48_MAX;
		else if (v < 56'(F48_MIN))
			r = F48_MIN;
		else
			r = v[47:0];
		return r;
	endfunction

endpackage

// ===== rtl/core/uaf_div.sv =====
`timescale 1ns / 1ps
module uaf_div
	import uaf_pkg::*;
(
	input  logic               clk,
	input  logic               en,
	input  logic signed [31:0] spin,
	input  logic signed [31:0] den,
	output logic signed [31:0] u
);

	// stage registers of the restoring divider
	logic [32:0] rem_s [DIV_STAGES+1];
	logic [31:0] num_s [DIV_STAGES+1];
	logic [31:0] quo_s [DIV_STAGES+1];
	logic [31:0] den_s [DIV_STAGES+1];
	logic        neg_s [DIV_STAGES+1];
	logic        ovf_s [DIV_STAGES+1];

	logic [31:0] aspin;

	// magnitude of the spin component
	assign aspin = spin[31] ? 32'(-spin) : spin;

	// prep: quotient of 2^32 or more saturates; else start with the top bits
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= {3'b000, aspin[31:2]};
			num_s[0] <= {aspin[1:0], 30'd0};
			quo_s[0] <= '0;
			den_s[0] <= den;
			neg_s[0] <= spin[31];
			ovf_s[0] <= ({2'b00, aspin[31:2]} >= den);
		end
	end

	// iteration stages, DIV_STEPS quotient bits each
	for (genvar i = 1; i <= DIV_STAGES; i++) begin : g_iter
		logic [32:0] rem_n;
		logic [31:0] num_n;
		logic [31:0] quo_n;
		logic [32:0] trial;

		always_comb begin
			rem_n = rem_s[i-1];
			num_n = num_s[i-1];
			quo_n = quo_s[i-1];
			for (int k = 0; k < DIV_STEPS; k++) begin
				trial = {rem_n[31:0], num_n[31]};
				num_n = {num_n[30:0], 1'b0};
				if (trial >= {1'b0, den_s[i-1]}) begin
					rem_n = trial - {1'b0, den_s[i-1]};
					quo_n = {quo_n[30:0], 1'b1};
				end else begin
					rem_n = trial;
					quo_n = {quo_n[30:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i] <= rem_n;
				num_s[i] <= num_n;
				quo_s[i] <= quo_n;
				den_s[i] <= den_s[i-1];
				neg_s[i] <= neg_s[i-1];
				ovf_s[i] <= ovf_s[i-1];
			end
		end
	end

	// apply sign and saturate to Q2.30
	always_ff @(posedge clk) begin
		if (en) begin
			if (ovf_s[DIV_STAGES])
				u <= neg_s[DIV_STAGES] ? Q30_MIN : Q30_MAX;
			else if (!neg_s[DIV_STAGES])
				u <= (quo_s[DIV_STAGES] > 32'h7fff_ffff) ? Q30_MAX : quo_s[DIV_STAGES];
			else
				u <= (quo_s[DIV_STAGES] > 32'h8000_0000) ? Q30_MIN
					: 32'(-quo_s[DIV_STAGES]);
		end
	end

endmodule

// ===== rtl/core/uaf_wmul.sv =====
`timescale 1ns / 1ps
module uaf_wmul
	import uaf_pkg::*;
(
	input  logic               clk,
	input  logic               en,
	input  logic signed [39:0] a,
	input  logic signed [31:0] b,
	output logic signed [71:0] p
);

	logic signed [48:0] pl_s1;
	logic signed [55:0] ph_s1;

	// partial products: unsigned low 16 bits and signed high 24 bits of a
	always_ff @(posedge clk) begin
		if (en) begin
			pl_s1 <= $signed({1'b0, a[15:0]}) * b;
			ph_s1 <= $signed(a[39:16]) * b;
		end
	end

	// recombine
	always_ff @(posedge clk) begin
		if (en)
			p <= {ph_s1, 16'd0} + 72'(pl_s1);
	end

endmodule

// ===== rtl/core/uniaxial_anisotropy_field_core.sv =====
`timescale 1ns / 1ps
// channel   direction  handshake                 payload
// input     in         in_valid / in_ready       site_index, spin_*, sat_mag, axis_*, k_*, last_entry
// output    out        out_valid / out_ready     site_out, field_x/y/z, last_out
// config    in         cfg_we                    cfg_wdata (field_scale)
//
// one word per cycle unless the output word stalls: a 16 stage divider (2 quotient bits
// per stage) plus prep/sign registers, then 14 multiply and clamp stages.
// reset clears valid bits and sets field_scale to 1.0; data regs are not reset.
// the whole pipeline holds while the output word waits; bubbles are not squeezed out.
module uniaxial_anisotropy_field_core
	import uaf_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [19:0]        site_index,
	input  logic signed [31:0] spin_x,
	input  logic signed [31:0] spin_y,
	input  logic signed [31:0] spin_z,
	input  logic signed [31:0] sat_mag,
	input  logic signed [31:0] axis_x,
	input  logic signed [31:0] axis_y,
	input  logic signed [31:0] axis_z,
	input  logic signed [31:0] k_second,
	input  logic signed [31:0] k_fourth,
	input  logic               last_entry,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [19:0]        site_out,
	output logic signed [47:0] field_x,
	output logic signed [47:0] field_y,
	output logic signed [47:0] field_z,
	output logic               last_out,
	input  logic               cfg_we,
	input  logic signed [31:0] cfg_wdata
);

	logic en;
	logic [PIPE_DEPTH-1:0] vld_q;
	side_t side_q [PIPE_DEPTH];
	logic signed [31:0] scale_q;

	logic signed [31:0] u [3];
	logic signed [63:0] pa_s1 [3];
	logic signed [31:0] d_s2, d_s3, d_s4;
	logic signed [63:0] dd_s3, k1p_s3;
	logic signed [31:0] d2_s4;
	logic signed [33:0] t1_s4, t1_s5, t1_s6, t1_s7;
	logic signed [63:0] d3p_s5;
	logic signed [31:0] d3_s6;
	logic signed [63:0] k2p_s7;
	logic signed [36:0] mag_s8;
	logic signed [71:0] pa10 [3];
	logic signed [38:0] g_s11 [3];
	logic signed [71:0] pb13 [3];
	logic signed [47:0] field_s14 [3];
	logic signed [31:0] ax_tap [3];
	logic signed [35:0] dsum;
	logic signed [63:0] dd_sh, d3p_sh, k1_sh, k2_sh;

	// global advance: stall only when the output word is not taken
	assign en = !vld_q[PIPE_DEPTH-1] || out_ready;
	assign in_ready = en;

	// field scale register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			scale_q <= SCALE_RESET;
		else if (cfg_we)
			scale_q <= cfg_wdata;
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (en)
			vld_q <= {vld_q[PIPE_DEPTH-2:0], in_valid};
	end

	// side data shift line
	always_ff @(posedge clk) begin
		if (en) begin
			side_q[0].site <= site_index;
			side_q[0].last <= last_entry;
			side_q[0].pos <= (sat_mag > 32'sd0);
			side_q[0].axis_x <= axis_x;
			side_q[0].axis_y <= axis_y;
			side_q[0].axis_z <= axis_z;
			side_q[0].k1 <= k_second;
			side_q[0].k2 <= k_fourth;
			for (int i = 1; i < PIPE_DEPTH; i++)
				side_q[i] <= side_q[i-1];
		end
	end

	// normalize spin by the magnitude
	uaf_div u_div_x (.clk, .en, .spin(spin_x), .den(sat_mag), .u(u[0]));
	uaf_div u_div_y (.clk, .en, .spin(spin_y), .den(sat_mag), .u(u[1]));
	uaf_div u_div_z (.clk, .en, .spin(spin_z), .den(sat_mag), .u(u[2]));

	// projection products
	always_ff @(posedge clk) begin
		if (en) begin
			pa_s1[0] <= side_q[TAP0].axis_x * u[0];
			pa_s1[1] <= side_q[TAP0].axis_y * u[1];
			pa_s1[2] <= side_q[TAP0].axis_z * u[2];
		end
	end

	// sum of floored terms, clamp
	always_comb begin
		dsum = 36'(pa_s1[0] >>> 30) + 36'(pa_s1[1] >>> 30) + 36'(pa_s1[2] >>> 30);
		dd_sh = dd_s3 >>> 30;
		d3p_sh = d3p_s5 >>> 30;
		k1_sh = k1p_s3 >>> 30;
		k2_sh = k2p_s7 >>> 30;
	end

	// d, d squared, K1 term, d cubed, K2 term, magnitude
	always_ff @(posedge clk) begin
		if (en) begin
			d_s2 <= sat_q30(dsum);
			dd_s3 <= d_s2 * d_s2;
			k1p_s3 <= side_q[TAP0+2].k1 * d_s2;
			d_s3 <= d_s2;
			d2_s4 <= sat_q30(dd_sh[35:0]);
			t1_s4 <= k1_sh[33:0];
			d_s4 <= d_s3;
			d3p_s5 <= d2_s4 * d_s4;
			t1_s5 <= t1_s4;
			d3_s6 <= sat_q30(d3p_sh[35:0]);
			t1_s6 <= t1_s5;
			k2p_s7 <= side_q[TAP0+6].k2 * d3_s6;
			t1_s7 <= t1_s6;
			mag_s8 <= (37'(t1_s7) <<< 1) + (37'($signed(k2_sh[33:0])) <<< 2);
		end
	end

	assign ax_tap[0] = side_q[TAP0+8].axis_x;
	assign ax_tap[1] = side_q[TAP0+8].axis_y;
	assign ax_tap[2] = side_q[TAP0+8].axis_z;

	// per-component axis and scale multiplies
	for (genvar c = 0; c < 3; c++) begin : g_comp
		uaf_wmul u_mul_g (
			.clk, .en,
			.a(40'(mag_s8)), .b(ax_tap[c]), .p(pa10[c])
		);

		always_ff @(posedge clk) begin
			if (en)
				g_s11[c] <= pa10[c][68:30];
		end

		uaf_wmul u_mul_f (
			.clk, .en,
			.a(40'(g_s11[c])), .b(scale_q), .p(pb13[c])
		);

		// floor by 2^16, clamp to 48 bit, zero for a non-positive magnitude
		always_ff @(posedge clk) begin
			if (en)
				field_s14[c] <= side_q[TAP0+13].pos ? sat_f48(pb13[c][71:16]) : '0;
		end
	end

	assign out_valid = vld_q[PIPE_DEPTH-1];
	assign site_out = side_q[PIPE_DEPTH-1].site;
	assign last_out = side_q[PIPE_DEPTH-1].last;
	assign field_x = field_s14[0];
	assign field_y = field_s14[1];
	assign field_z = field_s14[2];

endmodule
